// ----- design/cascaded_biquad_iir_top_assert.svh -----
// Assertion macros for the cascaded biquad filter top level.
// Needs clk_i and rst_ni in the scope that uses the macros.
`ifndef CASCADED_BIQUAD_IIR_TOP_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBIQ_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBIQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/cbiq_pkg.sv -----
// Types and constants of the cascaded biquad filter.
// No dependencies; imported by the top level.
package cbiq_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 24;
  localparam int CFG_W     = 4;
  localparam int NUM_SLOTS = 5;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // Five products of magnitude at most 2^46 fit well inside 51 signed bits.
  localparam int ACC_W     = 51;
  localparam int FRAC_SH   = 22;

  // Input tdata layout, lowest field first.
  localparam int IN_SAMPLE_LSB = 0;
  localparam int STAGE_W       = 3;
  localparam int IN_STAGE_LSB  = IN_SAMPLE_LSB + SAMPLE_W;
  localparam int SLOT_W        = 3;
  localparam int IN_SLOT_LSB   = IN_STAGE_LSB + STAGE_W;
  localparam int IN_COEF_LSB   = IN_SLOT_LSB + SLOT_W;
  localparam int IN_USED_W     = IN_COEF_LSB + COEF_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = SAMPLE_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [0:0] {
    OP_FILTER  = 1'b0,
    OP_COEF_WR = 1'b1
  } opcode_e;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_A0 = 3'd0,
    SLOT_A1 = 3'd1,
    SLOT_A2 = 3'd2,
    SLOT_B1 = 3'd3,
    SLOT_B2 = 3'd4
  } slot_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_OUT
  } state_e;

  // History of one section: x(n-1), x(n-2), y(n-1), y(n-2).
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_row_t;

endpackage

// ----- design/cascaded_biquad_iir_top.sv -----
// Cascaded direct-form-I biquad filter: one multiply-accumulate unit, sequencer,
// coefficient and history memories. Depends on cbiq_pkg and the assertion header.
//
// A sample item runs through the first active_stages sections (0 is taken as 1,
// values above MAX_STAGES as MAX_STAGES) on a single 24x24 multiplier. Each
// section issues its five products in ST_RUN, then spends ST_MUL on the last
// multiply, ST_ACC on the last accumulate and ST_FIN to round, saturate and
// write back its history row. After the last section, ST_OUT loads the output
// register once it is free and the block returns to idle. Sample items are
// only taken while idle, so a new sample waits until the previous one is
// through. A coefficient write item is taken while idle and gives no result.
// The output register lets a new item enter while the previous result waits.
// Both memories start out reading zero after reset through per-entry valid
// bits, so no clearing pass is needed.
`include "cascaded_biquad_iir_top_assert.svh"

module cascaded_biquad_iir_top #(
  parameter int MAX_STAGES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // sample_in[23:0], coef_stage[26:24], coef_slot[29:27], coef_value[53:30]
  input  logic [cbiq_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // opcode[0]
  input  logic [0:0]                          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // sample_out[23:0]
  output logic [cbiq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cbiq_pkg::CFG_W-1:0]          cfg_data_i
);
  import cbiq_pkg::*;

  localparam int ST_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int NUM_COEF = MAX_STAGES * NUM_SLOTS;
  localparam int CA_W     = $clog2(NUM_COEF);
  localparam int SH_W     = ACC_W - FRAC_SH;

  state_e                state_q, state_d;
  logic [ST_W-1:0]       stage_q, last_q, last_d, row_ra;
  slot_e                 step_q;
  logic [CFG_W-1:0]      active_q;
  sample_t               x_cur_q;
  hist_row_t             row_q, row_wr;
  sample_t               coef_q, coef_eff, op_d, op_q;
  logic                  coef_rdv_q;
  logic                  neg_d, neg_q, neg2_q;
  logic                  opv_q, prod_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, acc_rnd, prod_ext;
  logic signed [SH_W-1:0]   acc_sh;
  sample_t               y_sat;
  logic                  out_vld_q;
  sample_t               out_data_q;

  sample_t               coef_mem [NUM_COEF];
  logic [NUM_COEF-1:0]   coef_vld_q;
  hist_row_t             hist_mem [MAX_STAGES];
  logic [MAX_STAGES-1:0] hist_vld_q;

  logic                  in_acc, smp_acc, cw_acc, cw_ok, issue, fin, fin_last;
  logic                  out_free, row_ld;
  opcode_e               in_op;
  sample_t               in_sample, in_coef;
  logic [STAGE_W-1:0]    in_stage;
  logic [SLOT_W-1:0]     in_slot;
  logic [CA_W-1:0]       cw_addr, cr_addr;
  logic [CFG_W:0]        sec_count;

  // Input field decode and handshake.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op     = opcode_e'(s_axis_tuser_i[0]);
  assign in_sample = s_axis_tdata_i[IN_SAMPLE_LSB +: SAMPLE_W];
  assign in_stage  = s_axis_tdata_i[IN_STAGE_LSB +: STAGE_W];
  assign in_slot   = s_axis_tdata_i[IN_SLOT_LSB +: SLOT_W];
  assign in_coef   = s_axis_tdata_i[IN_COEF_LSB +: COEF_W];
  assign smp_acc   = in_acc && (in_op == OP_FILTER);
  assign cw_acc    = in_acc && (in_op == OP_COEF_WR);
  assign cw_ok     = (32'(in_stage) < MAX_STAGES) && (32'(in_slot) < NUM_SLOTS);
  assign cw_addr   = CA_W'(32'(in_stage) * NUM_SLOTS + 32'(in_slot));

  // Clamp the section count and keep the index of the last section.
  always_comb begin
    if (active_q == '0) begin
      sec_count = (CFG_W+1)'(1);
    end else if (32'(active_q) > MAX_STAGES) begin
      sec_count = (CFG_W+1)'(MAX_STAGES);
    end else begin
      sec_count = {1'b0, active_q};
    end
    last_d = ST_W'(sec_count - (CFG_W+1)'(1));
  end

  // Sequencer strobes and memory addresses.
  assign issue    = (state_q == ST_RUN);
  assign fin      = (state_q == ST_FIN);
  assign fin_last = (stage_q == last_q);
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign cr_addr  = CA_W'(32'(stage_q) * NUM_SLOTS + 32'(step_q));
  assign row_ld   = smp_acc || fin;
  assign row_ra   = (fin && !fin_last) ? ST_W'(stage_q + 1'b1) : '0;

  // Operand for the current product: the section input or one history tap.
  always_comb begin
    neg_d = (step_q inside {SLOT_B1, SLOT_B2});
    case (step_q)
      SLOT_A0: op_d = x_cur_q;
      SLOT_A1: op_d = row_q.x1;
      SLOT_A2: op_d = row_q.x2;
      SLOT_B1: op_d = row_q.y1;
      SLOT_B2: op_d = row_q.y2;
      default: op_d = '0;
    endcase
  end

  // Accumulate, then round half up and saturate the section output.
  assign coef_eff = coef_rdv_q ? coef_q : '0;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = neg2_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
  assign acc_rnd  = acc_q + (ACC_W'(1) <<< (FRAC_SH - 1));
  assign acc_sh   = acc_rnd[ACC_W-1:FRAC_SH];

  always_comb begin
    if (acc_sh[SH_W-1:SAMPLE_W-1] != {(SH_W-SAMPLE_W+1){acc_sh[SAMPLE_W-1]}}) begin
      y_sat = acc_sh[SH_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_sat = acc_sh[SAMPLE_W-1:0];
    end
  end

  // New history row of the finished section.
  always_comb begin
    row_wr.x1 = x_cur_q;
    row_wr.x2 = row_q.x1;
    row_wr.y1 = y_sat;
    row_wr.y2 = row_q.y1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (smp_acc) state_d = ST_RUN;
      ST_RUN:  if (step_q == SLOT_B2) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_FIN;
      ST_FIN:  state_d = fin_last ? ST_OUT : ST_RUN;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers: counters, pipeline valids, valid bits, configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= '0;
      last_q     <= '0;
      step_q     <= SLOT_A0;
      active_q   <= CFG_W'(1);
      opv_q      <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      coef_vld_q <= '0;
      hist_vld_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
      if (smp_acc) begin
        stage_q <= '0;
        last_q  <= last_d;
        step_q  <= SLOT_A0;
      end else if (issue) begin
        step_q <= (step_q == SLOT_B2) ? SLOT_A0 : slot_e'(step_q + 1'b1);
      end else if (fin && !fin_last) begin
        stage_q <= ST_W'(stage_q + 1'b1);
      end
      opv_q      <= issue;
      prod_vld_q <= opv_q;
      if (state_q == ST_OUT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cw_acc && cw_ok) begin
        coef_vld_q[cw_addr] <= 1'b1;
      end
      if (fin) begin
        hist_vld_q[stage_q] <= 1'b1;
      end
    end
  end

  // Coefficient memory: written by coefficient items, read once per product.
  always_ff @(posedge clk_i) begin
    if (cw_acc && cw_ok) begin
      coef_mem[cw_addr] <= in_coef;
    end
    if (issue) begin
      coef_q     <= coef_mem[cr_addr];
      coef_rdv_q <= coef_vld_q[cr_addr];
    end
  end

  // History memory: one row per section, read for the next section while
  // the finished section writes its row back.
  always_ff @(posedge clk_i) begin
    if (fin) begin
      hist_mem[stage_q] <= row_wr;
    end
    if (row_ld) begin
      row_q <= hist_vld_q[row_ra] ? hist_mem[row_ra] : '0;
    end
  end

  // Datapath: operand register, multiplier, accumulator, section value.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      op_q  <= op_d;
      neg_q <= neg_d;
    end
    prod_q <= PROD_W'(coef_eff) * PROD_W'(op_q);
    neg2_q <= neg_q;
    if (smp_acc || (fin && !fin_last)) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_d;
    end
    if (smp_acc) begin
      x_cur_q <= in_sample;
    end else if (fin) begin
      x_cur_q <= y_sat;
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= x_cur_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // A product still in flight means the block is busy.
  `CBIQ_ASSERT_IMPL(a_busy_while_mac, (opv_q || prod_vld_q), !s_axis_tready_o, "item accepted with products in flight")
  // A section that is not the last restarts the sequencer with a clear accumulator.
  `CBIQ_ASSERT_NEXT(a_stage_restart, (state_q == ST_FIN && stage_q != last_q), (state_q == ST_RUN && step_q == SLOT_A0 && acc_q == '0), "next section did not start cleanly")
  // The section counter never passes the last active section.
  `CBIQ_ASSERT_IMPL(a_stage_bound, (state_q != ST_IDLE), (stage_q <= last_q), "section index beyond last active section")
  // Loading the output register presents the final section value.
  `CBIQ_ASSERT_NEXT(a_result_load, (state_q == ST_OUT && out_free), (m_axis_tvalid_o && m_axis_tdata_o == $past(x_cur_q)), "result not loaded from last section")

endmodule

// ----- tb/sv/cascaded_biquad_iir_top_test.sv -----
// Self-checking testbench for the cascaded biquad filter top level.
// Depends on cbiq_pkg and cascaded_biquad_iir_top; predicts every filtered
// sample in place and compares it with the output stream.
module cascaded_biquad_iir_top_test;
  import cbiq_pkg::*;

  localparam int MAX_STAGES     = 8;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam sample_t ONE_Q22    = 24'sh400000;
  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;
  localparam sample_t HALF_LSB   = 24'sh200000;

  typedef struct {
    opcode_e            op;
    sample_t            smp;
    logic [STAGE_W-1:0] stage;
    logic [SLOT_W-1:0]  slot;
    sample_t            coef;
  } biquad_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;

  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int fail_count = 0;
  int quiet_cycles = 0;

  // Predicted filter state.
  logic [CFG_W-1:0] stage_setting;
  sample_t coef_bank [MAX_STAGES*NUM_SLOTS];
  sample_t x_hist [MAX_STAGES*2];
  sample_t y_hist [MAX_STAGES*2];
  sample_t expected_out [$];

  cascaded_biquad_iir_top #(
    .MAX_STAGES(MAX_STAGES)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Runs one sample through the active sections and updates their histories.
  function automatic sample_t run_cascade(sample_t x_in);
    int      n;
    int      c;
    longint  acc;
    longint  r;
    sample_t v;
    sample_t y;
    n = int'(stage_setting);
    if (n == 0) n = 1;
    if (n > MAX_STAGES) n = MAX_STAGES;
    v = x_in;
    for (int s = 0; s < n; s++) begin
      c = s * NUM_SLOTS;
      acc = longint'(coef_bank[c]) * longint'(v)
          + longint'(coef_bank[c+1]) * longint'(x_hist[2*s])
          + longint'(coef_bank[c+2]) * longint'(x_hist[2*s+1])
          - longint'(coef_bank[c+3]) * longint'(y_hist[2*s])
          - longint'(coef_bank[c+4]) * longint'(y_hist[2*s+1]);
      // Round half toward plus infinity, then saturate to 24 bits.
      r = (acc + 64'sd2097152) >>> FRAC_SH;
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      y = sample_t'(r);
      y_hist[2*s+1] = y_hist[2*s];
      y_hist[2*s]   = y;
      x_hist[2*s+1] = x_hist[2*s];
      x_hist[2*s]   = v;
      v = y;
    end
    return v;
  endfunction

  function automatic biquad_item_t make_sample(sample_t value);
    biquad_item_t it;
    it.op    = OP_FILTER;
    it.smp   = value;
    it.stage = STAGE_W'($urandom);
    it.slot  = SLOT_W'($urandom);
    it.coef  = sample_t'($urandom);
    return it;
  endfunction

  function automatic biquad_item_t make_coef(int stage, int slot, sample_t value);
    biquad_item_t it;
    it.op    = OP_COEF_WR;
    it.smp   = sample_t'($urandom);
    it.stage = STAGE_W'(stage);
    it.slot  = SLOT_W'(slot);
    it.coef  = value;
    return it;
  endfunction

  // Mostly modest coefficients so the cascade does not sit in saturation.
  function automatic biquad_item_t random_item();
    biquad_item_t it;
    it.op    = ($urandom_range(0, 4) == 0) ? OP_COEF_WR : OP_FILTER;
    it.stage = STAGE_W'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) it.slot = SLOT_W'($urandom_range(NUM_SLOTS, 7));
    else it.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    if ($urandom_range(0, 3) == 0) it.coef = sample_t'($urandom);
    else it.coef = sample_t'(int'($urandom_range(0, (1 << 22) - 1)) - (1 << 21));
    case ($urandom_range(0, 9))
      0: it.smp = SAMPLE_MAX;
      1: it.smp = SAMPLE_MIN;
      default: it.smp = sample_t'($urandom);
    endcase
    return it;
  endfunction

  // Offers one item, waits for the handshake and updates the prediction.
  task automatic send_item(input biquad_item_t it);
    bit taken;
    logic [IN_TDATA_W-1:0] word;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    word = '0;
    word[IN_SAMPLE_LSB +: SAMPLE_W] = it.smp;
    word[IN_STAGE_LSB +: STAGE_W]   = it.stage;
    word[IN_SLOT_LSB +: SLOT_W]     = it.slot;
    word[IN_COEF_LSB +: COEF_W]     = it.coef;
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= word;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    if (it.op == OP_FILTER) begin
      expected_out.push_back(run_cascade(it.smp));
    end else if (it.slot < NUM_SLOTS && it.stage < MAX_STAGES) begin
      coef_bank[it.stage * NUM_SLOTS + it.slot] = it.coef;
    end
  endtask

  // Waits until every predicted sample is out and the sequencer is done.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stage_count(input logic [CFG_W-1:0] value);
    bit taken;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    stage_setting = value;
  endtask

  // Identity, rounding, saturation, bad slots and stage-count extremes.
  task automatic test_directed_cases();
    write_stage_count(4'd1);
    send_item(make_sample(24'sh123456));
    send_item(make_coef(0, SLOT_A0, ONE_Q22));
    send_item(make_sample(SAMPLE_MAX));
    send_item(make_sample(SAMPLE_MIN));
    // Writes to slots past b2 must leave the coefficients alone.
    for (int k = NUM_SLOTS; k < 8; k++) send_item(make_coef(0, k, SAMPLE_MAX));
    send_item(make_sample(24'sd1234));
    // A one-LSB gain exposes the rounding of exact halves.
    send_item(make_coef(0, SLOT_A0, 24'sd1));
    send_item(make_sample(HALF_LSB));
    send_item(make_sample(-HALF_LSB));
    send_item(make_sample(-HALF_LSB - 24'sd1));
    send_item(make_coef(0, SLOT_A0, SAMPLE_MAX));
    send_item(make_sample(SAMPLE_MAX));
    send_item(make_coef(0, SLOT_A0, SAMPLE_MIN));
    send_item(make_sample(SAMPLE_MIN));
    send_item(make_sample(SAMPLE_MAX));
    // Extreme feedback and feedforward drive the accumulator past range.
    send_item(make_coef(0, SLOT_A1, SAMPLE_MIN));
    send_item(make_coef(0, SLOT_A2, SAMPLE_MAX));
    send_item(make_coef(0, SLOT_B1, SAMPLE_MAX));
    send_item(make_coef(0, SLOT_B2, SAMPLE_MIN));
    send_item(make_sample(24'sd0));
    // A count of zero acts as one section.
    write_stage_count(4'd0);
    send_item(make_sample(SAMPLE_MAX));
    // A count above the section total acts as the total.
    write_stage_count(4'd15);
    send_item(make_coef(7, SLOT_A0, ONE_Q22));
    send_item(make_sample(SAMPLE_MIN));
  endtask

  // Several stage counts, each with a run of mixed random items.
  task automatic test_random_phases();
    logic [CFG_W-1:0] counts [5];
    logic [CFG_W-1:0] n;
    counts = '{4'd8, 4'd3, 4'd15, 4'd0, 4'd9};
    for (int p = 0; p < 6; p++) begin
      n = (p < 5) ? counts[p] : CFG_W'($urandom_range(0, 15));
      write_stage_count(n);
      idle_en = (p != 2);
      repeat (110) send_item(random_item());
    end
    idle_en = 1'b1;
  endtask

  // The output is held off while samples keep coming, so the input stalls.
  task automatic test_output_backpressure();
    write_stage_count(4'd2);
    hold_req = 1'b1;
    repeat (40) send_item(make_sample(sample_t'($urandom)));
  endtask

  // Closing stretch with no input gaps and the output always ready.
  task automatic test_no_idle_tail();
    write_stage_count(4'd4);
    idle_en = 1'b0;
    repeat (125) send_item(random_item());
  endtask

  // Output ready: random stall bursts, plus one long hold on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compares each output item with the oldest prediction.
  initial begin
    sample_t want;
    forever begin
      @(negedge clk);
      if (rst_n && m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected sample_out, expected none, actual %0d",
                   $time, $signed(m_tdata));
          fail_count++;
        end else begin
          want = expected_out.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, $signed(m_tdata));
            fail_count++;
          end
        end
      end
    end
  end

  // Ends a run in which no channel moves an item for too long.
  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d samples still expected", $time, expected_out.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stage_setting = 4'd1;
    foreach (coef_bank[i]) coef_bank[i] = '0;
    foreach (x_hist[i]) x_hist[i] = '0;
    foreach (y_hist[i]) y_hist[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_phases();
    test_output_backpressure();
    test_no_idle_tail();

    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/cbiq_pkg.sv
design/cascaded_biquad_iir_top.sv
tb/sv/cascaded_biquad_iir_top_test.sv
